// File: design/html_tag_class_collector_assert.svh
// Assertion macros for the tag and class collector.
// Taken in by the table and top-level files; no other dependencies.
`ifndef HTML_TAG_CLASS_COLLECTOR_ASSERT_SVH
`define HTML_TAG_CLASS_COLLECTOR_ASSERT_SVH

`ifndef SYNTH
`define CTC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define CTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CTC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CTC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: design/ctc_pkg.sv
// Shared types and constants for the tag and class collector.
// No dependencies.
package ctc_pkg;

    localparam int TAG_SLOTS_DEF   = 64;
    localparam int CLASS_SLOTS_DEF = 64;
    localparam int TOKEN_BYTES_DEF = 32;

    localparam logic [1:0] CMD_HTML = 2'd0;
    localparam logic [1:0] CMD_EOD  = 2'd1;
    localparam logic [1:0] CMD_KEY  = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data_byte;
        logic       key_last;
    } t_in_word;

    typedef struct packed {
        logic       matched;
        logic       overflow_seen;
        logic [6:0] tag_total;
        logic [6:0] class_total;
    } t_out_word;

    typedef struct packed {
        logic busy;
        logic hit;
        logic full;
    } t_tbl_status;

endpackage

// File: design/ctc_cell.sv
// One byte cell of a shift chain: takes its neighbour's byte on shift.
// No dependencies.
module ctc_cell (
    input  logic       i_clk,
    input  logic       i_shift,
    input  logic [7:0] i_byte,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// File: design/ctc_table.sv
// Bounded de-duplicated name table: sequential search over a row memory.
// Depends on ctc_pkg and html_tag_class_collector_assert.svh.
`include "html_tag_class_collector_assert.svh"
module ctc_table import ctc_pkg::*; #(
    parameter int SLOTS       = TAG_SLOTS_DEF,
    parameter int TOKEN_BYTES = TOKEN_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic                               i_insert,
    input  logic [TOKEN_BYTES*8-1:0]           i_name,
    input  logic [$clog2(TOKEN_BYTES+1)-1:0]   i_len,
    output t_tbl_status                        o_status,
    output logic [$clog2(SLOTS+1)-1:0]         o_count
);

    localparam int NW = TOKEN_BYTES * 8;
    localparam int LW = $clog2(TOKEN_BYTES + 1);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [NW-1:0] mem_name [SLOTS];
    logic [LW-1:0] mem_len  [SLOTS];

    logic [NW-1:0] r_name, r_rd_name;
    logic [LW-1:0] r_len, r_rd_len;
    logic          r_ins, r_busy, r_hit, r_full, r_pend;
    logic [CW-1:0] r_issue, r_count;

    logic row_eq, match, can_issue, finish, do_write;

    // names are right-anchored in the row: only the low r_len bytes count
    always_comb begin
        row_eq = (r_rd_len == r_len);
        for (int b = 0; b < TOKEN_BYTES; b++) begin
            if ((LW'(b) < r_len) && (r_rd_name[b*8 +: 8] != r_name[b*8 +: 8])) begin
                row_eq = 1'b0;
            end
        end
    end

    assign match     = r_pend && row_eq;
    assign can_issue = r_busy && !match && (r_issue < r_count);
    assign finish    = r_busy && (match || (!r_pend && (r_issue == r_count)));
    assign do_write  = finish && r_ins && !match && (r_count < CW'(SLOTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_hit   <= 1'b0;
            r_full  <= 1'b0;
            r_pend  <= 1'b0;
            r_issue <= '0;
            r_count <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_hit   <= 1'b0;
            r_full  <= 1'b0;
            r_pend  <= 1'b0;
            r_issue <= '0;
        end else if (r_busy) begin
            r_pend <= can_issue;
            if (can_issue) begin
                r_issue <= r_issue + CW'(1);
            end
            if (finish) begin
                r_busy <= 1'b0;
                r_hit  <= match;
                if (r_ins && !match && (r_count >= CW'(SLOTS))) begin
                    r_full <= 1'b1;
                end
            end
            if (do_write) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_name <= i_name;
            r_len  <= i_len;
            r_ins  <= i_insert;
        end
        if (can_issue) begin
            r_rd_name <= mem_name[r_issue[IW-1:0]];
            r_rd_len  <= mem_len[r_issue[IW-1:0]];
        end
        if (do_write) begin
            mem_name[r_count[IW-1:0]] <= r_name;
            mem_len[r_count[IW-1:0]]  <= r_len;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.hit  = r_hit;
    assign o_status.full = r_full;
    assign o_count       = r_count;

    `CTC_ASSERT_IMPL(a_no_restart, i_clk, i_rst_n, i_start, !r_busy)
    `CTC_ASSERT_IMPL(a_full_only_when_full, i_clk, i_rst_n, r_full, r_count == CW'(SLOTS))
    `CTC_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(SLOTS))

endmodule

// File: design/html_tag_class_collector.sv
// Top level: HTML scanner, token and key byte chains, two name tables.
// Depends on ctc_pkg, ctc_cell, ctc_table and html_tag_class_collector_assert.svh.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+-----------
//  in      | input     | i_in_valid / o_in_ready   | i_in_word
//  out     | output    | o_out_valid / i_out_ready | o_out_word
//
// An html byte that ends no name does not stall the input. A byte that completes a name holds the
// input for a table search; end of document holds it for a search and then for its result.
// A final key byte searches the tables that its key parts need, in parallel; a hit ends a
// search early, and a key that cannot match skips the search.
// Reset is synchronous; there is no clearing pass. A result waits in the output
// register without blocking input until the next result is due; that one stalls until
// the register drains.
`include "html_tag_class_collector_assert.svh"
module html_tag_class_collector import ctc_pkg::*; #(
    parameter int TAG_SLOTS   = TAG_SLOTS_DEF,
    parameter int CLASS_SLOTS = CLASS_SLOTS_DEF,
    parameter int TOKEN_BYTES = TOKEN_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    localparam int NW  = TOKEN_BYTES * 8;
    localparam int TLW = $clog2(TOKEN_BYTES + 1);
    localparam int TCW = $clog2(TAG_SLOTS + 1);
    localparam int CCW = $clog2(CLASS_SLOTS + 1);

    localparam logic [3:0] ST_TEXT         = 4'd0;
    localparam logic [3:0] ST_TAG_OPEN     = 4'd1;
    localparam logic [3:0] ST_SKIP         = 4'd2;
    localparam logic [3:0] ST_TAG_NAME     = 4'd3;
    localparam logic [3:0] ST_IN_TAG       = 4'd4;
    localparam logic [3:0] ST_ATTR_NAME    = 4'd5;
    localparam logic [3:0] ST_AFTER_ATTR   = 4'd6;
    localparam logic [3:0] ST_BEFORE_VALUE = 4'd7;
    localparam logic [3:0] ST_ATTR_VALUE   = 4'd8;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ADD    = 3'd1;
    localparam logic [2:0] S_KSTART = 3'd2;
    localparam logic [2:0] S_LOOK   = 3'd3;
    localparam logic [2:0] S_PUT    = 3'd4;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_USCR  = 8'h5F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUERY = 8'h3F;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [7:0] CH_G     = 8'h67;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_S     = 8'h73;

    function automatic logic f_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic f_name_char(input logic [7:0] c);
        return f_alpha(c) || ((c >= 8'h30) && (c <= 8'h39)) ||
               (c == CH_DASH) || (c == CH_USCR) || (c == CH_COLON);
    endfunction

    function automatic logic f_space(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h0C);
    endfunction

    function automatic logic [7:0] f_lower(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
    endfunction

    t_in_word   w;
    logic [7:0] c;
    logic       acc;

    logic [2:0]     r_state;
    logic [3:0]     r_scan, n_scan;
    logic [TLW-1:0] r_tok_len, n_tok_len;
    logic           r_tok_long, n_tok_long;
    logic           r_in_class, n_in_class;
    logic [7:0]     r_quote, n_quote;
    logic           r_ovf, r_eod, r_m;
    logic           r_out_valid;
    t_out_word      r_out;
    logic           r_dot, n_dot;
    logic [TLW-1:0] r_kt_len, n_kt_len, r_kc_len, n_kc_len;
    logic           r_kt_long, n_kt_long, r_kc_long, n_kc_long;
    logic           r_need_tag, r_need_cls;

    logic           tok_shift, kt_shift, kc_shift;
    logic [7:0]     tok_byte;
    logic           add_tag, add_cls, is_class_word;
    logic           key_done, need_tag, need_cls, key_fail, key_clear;
    logic           put_fire;

    logic [NW-1:0]  tok_vec, kt_vec, kc_vec, img_name;
    logic [NW-1:0]  tok_in, kt_in, kc_in;

    logic           tag_start, tag_ins, cls_start;
    logic [NW-1:0]  tag_name, cls_name;
    logic [TLW-1:0] tag_len, cls_len;
    t_tbl_status    tag_st, cls_st;
    logic [TCW-1:0] tag_count;
    logic [CCW-1:0] cls_count;

    assign w   = i_in_word;
    assign c   = w.data_byte;
    assign acc = i_in_valid && o_in_ready;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign put_fire    = (r_state == S_PUT) && (!r_out_valid || i_out_ready);

    // byte chains: cell 0 takes the new byte, names sit right-anchored
    assign tok_byte = f_lower(c);
    assign tok_in   = {tok_vec[NW-9:0], tok_byte};
    assign kt_in    = {kt_vec[NW-9:0], c};
    assign kc_in    = {kc_vec[NW-9:0], c};
    assign img_name = {{(NW-24){1'b0}}, CH_I, CH_M, CH_G};

    for (genvar g = 0; g < TOKEN_BYTES; g++) begin : g_chain
        ctc_cell u_tok (.i_clk(i_clk), .i_shift(tok_shift), .i_byte(tok_in[g*8 +: 8]),
                        .o_byte(tok_vec[g*8 +: 8]));
        ctc_cell u_kt  (.i_clk(i_clk), .i_shift(kt_shift), .i_byte(kt_in[g*8 +: 8]),
                        .o_byte(kt_vec[g*8 +: 8]));
        ctc_cell u_kc  (.i_clk(i_clk), .i_shift(kc_shift), .i_byte(kc_in[g*8 +: 8]),
                        .o_byte(kc_vec[g*8 +: 8]));
    end

    if (TOKEN_BYTES >= 5) begin : g_cls_word
        assign is_class_word = !r_tok_long && (r_tok_len == TLW'(5)) &&
                               (tok_vec[7:0] == CH_S) && (tok_vec[15:8] == CH_S) &&
                               (tok_vec[23:16] == CH_A) && (tok_vec[31:24] == CH_L) &&
                               (tok_vec[39:32] == CH_C);
    end else begin : g_no_cls_word
        assign is_class_word = 1'b0;
    end

    // scanner
    always_comb begin
        n_scan     = r_scan;
        n_tok_len  = r_tok_len;
        n_tok_long = r_tok_long;
        n_in_class = r_in_class;
        n_quote    = r_quote;
        tok_shift  = 1'b0;
        add_tag    = 1'b0;
        add_cls    = 1'b0;
        if (acc && (w.cmd == CMD_HTML)) begin
            unique case (r_scan)
                ST_TEXT: begin
                    if (c == CH_LT) n_scan = ST_TAG_OPEN;
                end
                ST_TAG_OPEN: begin
                    if ((c == CH_SLASH) || (c == CH_BANG) || (c == CH_QUERY)) begin
                        n_scan = ST_SKIP;
                    end else if (f_alpha(c)) begin
                        tok_shift  = 1'b1;
                        n_tok_len  = TLW'(1);
                        n_tok_long = 1'b0;
                        n_scan     = ST_TAG_NAME;
                    end else begin
                        n_scan = ST_TEXT;
                    end
                end
                ST_SKIP: begin
                    if (c == CH_GT) n_scan = ST_TEXT;
                end
                ST_TAG_NAME: begin
                    if (f_name_char(c)) begin
                        if (r_tok_len < TLW'(TOKEN_BYTES)) begin
                            tok_shift = 1'b1;
                            n_tok_len = r_tok_len + TLW'(1);
                        end else begin
                            n_tok_long = 1'b1;
                        end
                    end else begin
                        add_tag = !r_tok_long && !r_ovf && (r_tok_len != '0);
                        n_scan  = (c == CH_GT) ? ST_TEXT : ST_IN_TAG;
                    end
                end
                ST_IN_TAG: begin
                    if (c == CH_GT) begin
                        n_scan = ST_TEXT;
                    end else if (f_alpha(c)) begin
                        tok_shift  = 1'b1;
                        n_tok_len  = TLW'(1);
                        n_tok_long = 1'b0;
                        n_scan     = ST_ATTR_NAME;
                    end
                end
                ST_ATTR_NAME: begin
                    if (f_name_char(c)) begin
                        if (r_tok_len < TLW'(TOKEN_BYTES)) begin
                            tok_shift = 1'b1;
                            n_tok_len = r_tok_len + TLW'(1);
                        end else begin
                            n_tok_long = 1'b1;
                        end
                    end else begin
                        n_in_class = is_class_word;
                        n_scan = (c == CH_EQ) ? ST_BEFORE_VALUE :
                                 ((c == CH_GT) ? ST_TEXT : ST_AFTER_ATTR);
                    end
                end
                ST_AFTER_ATTR: begin
                    if (c == CH_EQ) begin
                        n_scan = ST_BEFORE_VALUE;
                    end else if (c == CH_GT) begin
                        n_scan = ST_TEXT;
                    end else if (f_alpha(c)) begin
                        tok_shift  = 1'b1;
                        n_tok_len  = TLW'(1);
                        n_tok_long = 1'b0;
                        n_scan     = ST_ATTR_NAME;
                    end
                end
                ST_BEFORE_VALUE: begin
                    if ((c == CH_DQ) || (c == CH_SQ)) begin
                        n_quote    = c;
                        n_tok_len  = '0;
                        n_tok_long = 1'b0;
                        n_scan     = ST_ATTR_VALUE;
                    end else if (c == CH_GT) begin
                        n_scan = ST_TEXT;
                    end else if (!f_space(c)) begin
                        n_scan = ST_IN_TAG;
                    end
                end
                ST_ATTR_VALUE: begin
                    if (c == r_quote) begin
                        add_cls = r_in_class && !r_tok_long && !r_ovf && (r_tok_len != '0);
                        n_scan  = ST_IN_TAG;
                    end else if (r_in_class) begin
                        if (f_space(c)) begin
                            // table latches the old token before the clear lands
                            add_cls    = !r_tok_long && !r_ovf && (r_tok_len != '0);
                            n_tok_len  = '0;
                            n_tok_long = 1'b0;
                        end else if (r_tok_len < TLW'(TOKEN_BYTES)) begin
                            tok_shift = 1'b1;
                            n_tok_len = r_tok_len + TLW'(1);
                        end else begin
                            n_tok_long = 1'b1;
                        end
                    end
                end
                default: n_scan = ST_TEXT;
            endcase
        end else if (acc && (w.cmd == CMD_EOD)) begin
            n_scan     = ST_TEXT;
            n_tok_len  = '0;
            n_tok_long = 1'b0;
            n_in_class = 1'b0;
            n_quote    = CH_DQ;
        end
    end

    // key bytes split at the first dot into tag and class parts
    always_comb begin
        n_dot     = r_dot;
        n_kt_len  = r_kt_len;
        n_kt_long = r_kt_long;
        n_kc_len  = r_kc_len;
        n_kc_long = r_kc_long;
        kt_shift  = 1'b0;
        kc_shift  = 1'b0;
        if (acc && (w.cmd == CMD_KEY)) begin
            if (!r_dot && (c == CH_DOT)) begin
                n_dot = 1'b1;
            end else if (!r_dot) begin
                if (r_kt_len < TLW'(TOKEN_BYTES)) begin
                    kt_shift = 1'b1;
                    n_kt_len = r_kt_len + TLW'(1);
                end else begin
                    n_kt_long = 1'b1;
                end
            end else begin
                if (r_kc_len < TLW'(TOKEN_BYTES)) begin
                    kc_shift = 1'b1;
                    n_kc_len = r_kc_len + TLW'(1);
                end else begin
                    n_kc_long = 1'b1;
                end
            end
        end
        key_done = acc && (w.cmd == CMD_KEY) && w.key_last;
        need_tag = !n_dot || (n_kt_len != '0);
        need_cls = n_dot;
        key_fail = (need_tag && ((n_kt_len == '0) || n_kt_long)) ||
                   (need_cls && ((n_kc_len == '0) || n_kc_long));
        // key emptied once the lookups have latched it, or at once when it cannot match
        key_clear = (r_state == S_KSTART) || (key_done && (r_ovf || key_fail));
    end

    // table requests
    always_comb begin
        tag_start = (acc && (w.cmd == CMD_HTML) && add_tag) ||
                    (acc && (w.cmd == CMD_EOD) && !r_ovf) ||
                    ((r_state == S_KSTART) && r_need_tag);
        tag_ins   = (r_state == S_IDLE);
        cls_start = (acc && (w.cmd == CMD_HTML) && add_cls) ||
                    ((r_state == S_KSTART) && r_need_cls);
        if (r_state == S_KSTART) begin
            tag_name = kt_vec;
            tag_len  = r_kt_len;
            cls_name = kc_vec;
            cls_len  = r_kc_len;
        end else begin
            tag_name = (w.cmd == CMD_EOD) ? img_name : tok_vec;
            tag_len  = (w.cmd == CMD_EOD) ? TLW'(3) : r_tok_len;
            cls_name = tok_vec;
            cls_len  = r_tok_len;
        end
    end

    ctc_table #(.SLOTS(TAG_SLOTS), .TOKEN_BYTES(TOKEN_BYTES)) u_tag_tbl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(tag_start), .i_insert(tag_ins),
        .i_name(tag_name), .i_len(tag_len), .o_status(tag_st), .o_count(tag_count)
    );

    ctc_table #(.SLOTS(CLASS_SLOTS), .TOKEN_BYTES(TOKEN_BYTES)) u_cls_tbl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(cls_start), .i_insert(tag_ins),
        .i_name(cls_name), .i_len(cls_len), .o_status(cls_st), .o_count(cls_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scan      <= ST_TEXT;
            r_tok_len   <= '0;
            r_tok_long  <= 1'b0;
            r_in_class  <= 1'b0;
            r_quote     <= CH_DQ;
            r_ovf       <= 1'b0;
            r_eod       <= 1'b0;
            r_m         <= 1'b0;
            r_out_valid <= 1'b0;
            r_dot       <= 1'b0;
            r_kt_len    <= '0;
            r_kt_long   <= 1'b0;
            r_kc_len    <= '0;
            r_kc_long   <= 1'b0;
            r_need_tag  <= 1'b0;
            r_need_cls  <= 1'b0;
        end else begin
            r_scan     <= n_scan;
            r_tok_len  <= n_tok_len;
            r_tok_long <= n_tok_long;
            r_in_class <= n_in_class;
            r_quote    <= n_quote;
            r_dot      <= key_clear ? 1'b0 : n_dot;
            r_kt_len   <= key_clear ? '0 : n_kt_len;
            r_kt_long  <= key_clear ? 1'b0 : n_kt_long;
            r_kc_len   <= key_clear ? '0 : n_kc_len;
            r_kc_long  <= key_clear ? 1'b0 : n_kc_long;
            if (put_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc && (w.cmd == CMD_HTML) && (add_tag || add_cls)) begin
                        r_eod   <= 1'b0;
                        r_state <= S_ADD;
                    end else if (acc && (w.cmd == CMD_EOD)) begin
                        r_eod   <= 1'b1;
                        r_m     <= 1'b0;
                        r_state <= r_ovf ? S_PUT : S_ADD;
                    end else if (key_done) begin
                        r_need_tag <= need_tag;
                        r_need_cls <= need_cls;
                        if (r_ovf || key_fail) begin
                            r_m     <= r_ovf;
                            r_state <= S_PUT;
                        end else begin
                            r_state <= S_KSTART;
                        end
                    end
                end
                S_ADD: begin
                    if (!tag_st.busy && !cls_st.busy) begin
                        if (tag_st.full || cls_st.full) r_ovf <= 1'b1;
                        r_state <= r_eod ? S_PUT : S_IDLE;
                    end
                end
                S_KSTART: begin
                    // lookups latch the key parts this edge
                    r_state <= S_LOOK;
                end
                S_LOOK: begin
                    if (!tag_st.busy && !cls_st.busy) begin
                        r_m <= (!r_need_tag || tag_st.hit) && (!r_need_cls || cls_st.hit);
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (put_fire) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (put_fire) begin
            r_out.matched       <= r_m;
            r_out.overflow_seen <= r_ovf;
            r_out.tag_total     <= 7'(tag_count);
            r_out.class_total   <= 7'(cls_count);
        end
    end

    `CTC_ASSERT_NEXT(a_ovf_sticky, i_clk, i_rst_n, r_ovf, r_ovf)
    `CTC_ASSERT_IMPL(a_tok_bound, i_clk, i_rst_n, 1'b1, r_tok_len <= TLW'(TOKEN_BYTES))
    `CTC_ASSERT_IMPL(a_idle_tables, i_clk, i_rst_n, o_in_ready, !tag_st.busy && !cls_st.busy)

endmodule
